/* rtl/ptmf_pkg.sv */
package ptmf_pkg;

  localparam int SAMPLE_W = 10;
  localparam int MEAN_W   = 14;
  localparam int PH_W     = 12;
  localparam int GAIN_W   = 18;
  localparam int OFFSET_W = 10;

  // The gain is Q16 and the mean carries 4 fraction bits, so the product is
  // scaled down by 2^20 with round half up.
  localparam int GAIN_FRAC = 20;

  // Register indexes; register i sits at byte address 4 * i.
  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = '1;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 18'd112000;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd25;
  localparam logic [PH_W-1:0]     PH_MAX       = 12'd4095;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [MEAN_W-1:0] trimmed_mean_x16;
    logic [PH_W-1:0]   ph_centi;
  } result_t;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_READ,
    WALK_FOLD,
    WALK_HOLD
  } walk_state_t;

  typedef enum logic [2:0] {
    SCALE_IDLE,
    SCALE_RECIP,
    SCALE_FIX,
    SCALE_GAIN,
    SCALE_OUT
  } scale_state_t;

endpackage

/* rtl/ptmf_fifo.sv */
module ptmf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/ptmf_window.sv */
module ptmf_window #(
  parameter int WINDOW = 40
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  ptmf_pkg::sample_t                                sample,
  input  logic                                             sample_valid,
  output logic                                             sample_take,
  output logic                                             stat_valid,
  input  logic                                             stat_ready,
  output logic [ptmf_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]     trimmed_sum
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = ptmf_pkg::SAMPLE_W + IDX_W;

  ptmf_pkg::sample_t     ring [WINDOW];
  logic [WINDOW-1:0]     filled;
  logic [IDX_W-1:0]      slot;
  logic [IDX_W-1:0]      idx;
  ptmf_pkg::walk_state_t state;
  ptmf_pkg::walk_state_t state_next;
  ptmf_pkg::sample_t     rd_data;
  logic                  rd_filled;
  logic                  rd_pend;
  ptmf_pkg::sample_t     fold_val;
  logic [SUM_W-1:0]      sum;
  ptmf_pkg::sample_t     lo;
  ptmf_pkg::sample_t     hi;

  // Slots never written since reset read as zero.
  assign fold_val    = rd_filled ? rd_data : '0;
  assign trimmed_sum = sum - SUM_W'(lo) - SUM_W'(hi);

  always_comb begin
    state_next  = state;
    sample_take = 1'b0;
    stat_valid  = 1'b0;
    case (state)
      ptmf_pkg::WALK_IDLE: begin
        if (sample_valid) begin
          sample_take = 1'b1;
          state_next  = ptmf_pkg::WALK_READ;
        end
      end
      ptmf_pkg::WALK_READ: begin
        if (idx == IDX_W'(WINDOW - 1)) begin
          state_next = ptmf_pkg::WALK_FOLD;
        end
      end
      ptmf_pkg::WALK_FOLD: begin
        state_next = ptmf_pkg::WALK_HOLD;
      end
      ptmf_pkg::WALK_HOLD: begin
        stat_valid = 1'b1;
        if (stat_ready) begin
          state_next = ptmf_pkg::WALK_IDLE;
        end
      end
      default: begin
        state_next = ptmf_pkg::WALK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      ring[slot] <= sample;
    end
    rd_data   <= ring[idx];
    rd_filled <= filled[idx];
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      sum <= '0;
      lo  <= ptmf_pkg::SAMPLE_MAX;
      hi  <= '0;
    end else if (rd_pend) begin
      sum <= sum + SUM_W'(fold_val);
      if (fold_val < lo) begin
        lo <= fold_val;
      end
      if (fold_val > hi) begin
        hi <= fold_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ptmf_pkg::WALK_IDLE;
      filled  <= '0;
      slot    <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ptmf_pkg::WALK_READ);
      if (sample_take) begin
        filled[slot] <= 1'b1;
        slot         <= (slot == IDX_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
        idx          <= '0;
      end else if (state == ptmf_pkg::WALK_READ && idx != IDX_W'(WINDOW - 1)) begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

/* rtl/ptmf_scale.sv */
module ptmf_scale #(
  parameter int WINDOW = 40
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         stat_valid,
  output logic                                         stat_ready,
  input  logic [ptmf_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] trimmed_sum,
  input  logic [ptmf_pkg::GAIN_W-1:0]                  gain,
  input  logic signed [ptmf_pkg::OFFSET_W-1:0]         offset,
  output logic                                         res_push,
  input  logic                                         res_full,
  output ptmf_pkg::result_t                            result
);

  localparam int SUM_W   = ptmf_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int NUM_W   = SUM_W + 4;
  localparam int PROD_W  = 2 * NUM_W;
  localparam int DIVISOR = WINDOW - 2;
  localparam int HALF    = DIVISOR / 2;
  // floor(2^NUM_W / DIVISOR) undershoots the quotient by at most one.
  localparam int RECIP   = (1 << NUM_W) / DIVISOR;
  localparam int GPROD_W = ptmf_pkg::MEAN_W + ptmf_pkg::GAIN_W;
  localparam int P_W     = GPROD_W + 1 - ptmf_pkg::GAIN_FRAC;
  localparam int PHS_W   = P_W + 2;

  ptmf_pkg::scale_state_t state;
  ptmf_pkg::scale_state_t state_next;

  logic [NUM_W-1:0]            num;
  logic [PROD_W-1:0]           prod;
  logic [ptmf_pkg::MEAN_W-1:0] mean;
  logic [GPROD_W-1:0]          gprod;
  logic [NUM_W-1:0]            q0;
  logic [NUM_W-1:0]            rem;
  logic [GPROD_W:0]            rounded;
  logic [P_W-1:0]              p;
  logic signed [PHS_W-1:0]     ph_sum;

  assign q0  = prod[PROD_W-1:NUM_W];
  assign rem = num - NUM_W'(q0 * NUM_W'(DIVISOR));

  assign rounded = {1'b0, gprod} + ((GPROD_W + 1)'(1) << (ptmf_pkg::GAIN_FRAC - 1));
  assign p       = rounded[GPROD_W:ptmf_pkg::GAIN_FRAC];
  assign ph_sum  = $signed({2'b00, p}) + $signed({{(PHS_W - ptmf_pkg::OFFSET_W){offset[
                   ptmf_pkg::OFFSET_W-1]}}, offset});

  always_comb begin
    result.trimmed_mean_x16 = mean;
    if (ph_sum < 0) begin
      result.ph_centi = '0;
    end else if (ph_sum > $signed(PHS_W'(ptmf_pkg::PH_MAX))) begin
      result.ph_centi = ptmf_pkg::PH_MAX;
    end else begin
      result.ph_centi = ph_sum[ptmf_pkg::PH_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    stat_ready = 1'b0;
    res_push   = 1'b0;
    case (state)
      ptmf_pkg::SCALE_IDLE: begin
        stat_ready = 1'b1;
        if (stat_valid) begin
          state_next = ptmf_pkg::SCALE_RECIP;
        end
      end
      ptmf_pkg::SCALE_RECIP: begin
        state_next = ptmf_pkg::SCALE_FIX;
      end
      ptmf_pkg::SCALE_FIX: begin
        state_next = ptmf_pkg::SCALE_GAIN;
      end
      ptmf_pkg::SCALE_GAIN: begin
        state_next = ptmf_pkg::SCALE_OUT;
      end
      ptmf_pkg::SCALE_OUT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = ptmf_pkg::SCALE_IDLE;
        end
      end
      default: begin
        state_next = ptmf_pkg::SCALE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ptmf_pkg::SCALE_IDLE: begin
        num <= {trimmed_sum, 4'b0000} + NUM_W'(HALF);
      end
      ptmf_pkg::SCALE_RECIP: begin
        prod <= PROD_W'(num) * PROD_W'(RECIP);
      end
      ptmf_pkg::SCALE_FIX: begin
        mean <= ptmf_pkg::MEAN_W'(q0 + NUM_W'(rem >= NUM_W'(DIVISOR)));
      end
      ptmf_pkg::SCALE_GAIN: begin
        gprod <= GPROD_W'(mean) * GPROD_W'(gain);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptmf_pkg::SCALE_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/ph_trimmed_mean_filter.sv */
// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+------------------------------
// samples   | in        | push / full                   | adc_sample
// results   | out       | empty / pop                   | trimmed_mean_x16, ph_centi
// registers | in/out    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Each sample passes the window walker in order: it is stored, the sample ring is read
// WINDOW times through its read port, the reads are folded into sum, min and max, and
// the result is handed off once the scaling unit is ready to take it.
// The scaling unit works after the hand-off but overlaps the next walk.
// Reset is synchronous and active high; it empties both queues and marks every
// ring slot as unwritten, so old slots count as zero with no clearing pass.
// Either side may stall: a short queue on each side absorbs the difference.
module ph_trimmed_mean_filter #(
  parameter int WINDOW      = 40,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,

  input  logic                                push,
  output logic                                full,
  input  logic [ptmf_pkg::SAMPLE_W-1:0]       adc_sample,

  output logic                                empty,
  input  logic                                pop,
  output logic [ptmf_pkg::MEAN_W-1:0]         trimmed_mean_x16,
  output logic [ptmf_pkg::PH_W-1:0]           ph_centi
);

  // Registers sit on 32-bit words; bit 2 of the address picks one and the byte
  // lane bits below it are ignored.

  localparam int SUM_W = ptmf_pkg::SAMPLE_W + $clog2(WINDOW);

  logic [ptmf_pkg::GAIN_W-1:0]          ph_gain_q16;
  logic signed [ptmf_pkg::OFFSET_W-1:0] ph_offset_centi;
  logic                                 cfg_write;

  ptmf_pkg::sample_t  q_sample;
  logic               q_empty;
  logic               sample_take;
  logic               stat_valid;
  logic               stat_ready;
  logic [SUM_W-1:0]   trimmed_sum;
  logic               res_push;
  logic               res_full;
  ptmf_pkg::result_t  res_in;
  ptmf_pkg::result_t  res_out;

  // The register port never waits, so a write completes in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      ptmf_pkg::REG_GAIN:   prdata = {{(32 - ptmf_pkg::GAIN_W){1'b0}}, ph_gain_q16};
      ptmf_pkg::REG_OFFSET: prdata = {{(32 - ptmf_pkg::OFFSET_W){1'b0}}, ph_offset_centi};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_gain_q16     <= ptmf_pkg::GAIN_RESET;
      ph_offset_centi <= ptmf_pkg::OFFSET_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        ptmf_pkg::REG_GAIN:   ph_gain_q16     <= pwdata[ptmf_pkg::GAIN_W-1:0];
        ptmf_pkg::REG_OFFSET: ph_offset_centi <= pwdata[ptmf_pkg::OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: incoming sample transfers land in a short queue.
  ptmf_fifo #(
    .WIDTH (ptmf_pkg::SAMPLE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (adc_sample),
    .full  (full),
    .pop   (sample_take),
    .rdata (q_sample),
    .empty (q_empty)
  );

  // Back, first half: store the sample, then walk the ring for sum, min and max.
  ptmf_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .sample       (q_sample),
    .sample_valid (!q_empty),
    .sample_take  (sample_take),
    .stat_valid   (stat_valid),
    .stat_ready   (stat_ready),
    .trimmed_sum  (trimmed_sum)
  );

  // Back, second half: divide by WINDOW-2 via reciprocal, apply gain and offset, and clamp.
  ptmf_scale #(
    .WINDOW (WINDOW)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .stat_valid  (stat_valid),
    .stat_ready  (stat_ready),
    .trimmed_sum (trimmed_sum),
    .gain        (ph_gain_q16),
    .offset      (ph_offset_centi),
    .res_push    (res_push),
    .res_full    (res_full),
    .result      (res_in)
  );

  // Finished results wait here until the consumer takes the transfer.
  ptmf_fifo #(
    .WIDTH ($bits(ptmf_pkg::result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign trimmed_mean_x16 = res_out.trimmed_mean_x16;
  assign ph_centi         = res_out.ph_centi;

endmodule
